/* hdl/bpfa_pkg.sv */
// shared constants, codes and types for the bitmap page frame allocator
`timescale 1ns / 1ps

package bpfa_pkg;

    localparam int MAX_PAGE_COUNT = 4096;
    localparam int PAGE_BYTES     = 4096;
    localparam int PAGE_SHIFT     = $clog2(PAGE_BYTES);

    localparam int OP_W     = 3;
    localparam int ADDR_W   = 32;
    localparam int TYPE_W   = 8;
    localparam int RUN_W    = 13;
    localparam int IDX_W    = 12;
    localparam int STATUS_W = 2;

    localparam int PAGE_W     = $clog2(MAX_PAGE_COUNT);
    localparam int PCNT_W     = PAGE_W + 1;
    localparam int WORD_BITS  = 64;
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int WORD_COUNT = MAX_PAGE_COUNT / WORD_BITS;
    localparam int WADDR_W    = $clog2(WORD_COUNT);
    localparam int WIDX_W     = WADDR_W + 1;
    localparam int RUN_END_W  = ((PCNT_W > RUN_W) ? PCNT_W : RUN_W) + 1;

    localparam logic [TYPE_W-1:0] REGION_USABLE = TYPE_W'(1);

    typedef enum logic [OP_W-1:0] {
        OP_FILL_USED     = 3'd0,
        OP_ADD_REGION    = 3'd1,
        OP_RESERVE_BELOW = 3'd2,
        OP_ALLOC_ONE     = 3'd3,
        OP_FREE_ONE      = 3'd4,
        OP_ALLOC_RUN     = 3'd5
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE       = 2'd0,
        STATUS_NO_FREE    = 2'd1,
        STATUS_NOT_CONTIG = 2'd2,
        STATUS_REJECTED   = 2'd3
    } status_t;

    typedef struct packed {
        logic [PCNT_W-1:0] lo;
        logic [PCNT_W-1:0] hi;
        logic              find_used;
        logic              set_bits;
    } unit_ctl_t;

    typedef struct packed {
        logic                 hit;
        logic [BIT_W-1:0]     bit_sel;
        logic [WORD_BITS-1:0] new_word;
    } unit_res_t;

endpackage

/* hdl/bpfa_word_unit.sv */
// shared word unit: page range mask, first-match search and bit update of one bitmap word
`timescale 1ns / 1ps

module bpfa_word_unit (
    input  bpfa_pkg::unit_ctl_t                     ctl,
    input  logic [bpfa_pkg::WADDR_W-1:0]            widx,
    input  logic [bpfa_pkg::WORD_BITS-1:0]          word,
    output bpfa_pkg::unit_res_t                     res
);

    logic [bpfa_pkg::PCNT_W-1:0]    wbase;
    logic [bpfa_pkg::PCNT_W-1:0]    wtop;
    logic [bpfa_pkg::BIT_W-1:0]     lo_off;
    logic [bpfa_pkg::BIT_W-1:0]     hi_off;
    logic [bpfa_pkg::WORD_BITS-1:0] lo_mask;
    logic [bpfa_pkg::WORD_BITS-1:0] hi_mask;
    logic [bpfa_pkg::WORD_BITS-1:0] mask;
    logic [bpfa_pkg::WORD_BITS-1:0] cand;
    logic [bpfa_pkg::BIT_W-1:0]     sel;

    assign wbase  = bpfa_pkg::PCNT_W'({widx, {bpfa_pkg::BIT_W{1'b0}}});
    assign wtop   = wbase + bpfa_pkg::PCNT_W'(bpfa_pkg::WORD_BITS);
    assign lo_off = bpfa_pkg::BIT_W'(ctl.lo - wbase);
    assign hi_off = bpfa_pkg::BIT_W'(ctl.hi - wbase);

    always_comb begin
        if (ctl.lo <= wbase) begin
            lo_mask = '1;
        end else if (ctl.lo >= wtop) begin
            lo_mask = '0;
        end else begin
            lo_mask = {bpfa_pkg::WORD_BITS{1'b1}} << lo_off;
        end
        if (ctl.hi >= wtop) begin
            hi_mask = '1;
        end else if (ctl.hi <= wbase) begin
            hi_mask = '0;
        end else begin
            hi_mask = ~({bpfa_pkg::WORD_BITS{1'b1}} << hi_off);
        end
    end

    assign mask = lo_mask & hi_mask;
    assign cand = (ctl.find_used ? word : ~word) & mask;

    // lowest matching bit
    always_comb begin
        sel = '0;
        for (int i = bpfa_pkg::WORD_BITS - 1; i >= 0; i--) begin
            if (cand[i]) begin
                sel = bpfa_pkg::BIT_W'(i);
            end
        end
    end

    assign res.hit      = |cand;
    assign res.bit_sel  = sel;
    assign res.new_word = ctl.set_bits ? (word | mask) : (word & ~mask);

endmodule

/* hdl/bitmap_page_frame_allocator_core.sv */
// top level of the bitmap page frame allocator: command sequencer, bitmap memory, result register
//
//  channel | direction | handshake         | payload
//  s_      | in        | s_valid / s_ready | s_opcode s_address s_region_length s_region_type
//          |           |                   | s_run_count
//  m_      | out       | m_valid / m_ready | m_ok m_frame_idx m_status
//
// the bitmap is 64 words of 64 bits, one read and one write memory port, swept one word a cycle
// fill_used, regions with no page to touch and rejected commands go from setup straight to done
// region commands that touch pages and free_one sweep the words they touch in the range state
// alloc_one is a scan of the bitmap followed by a one-word write
// alloc_run takes up to three scans, or up to two scans and a write
// reset clears the per-word valid bits at once, a word without its bit reads as all used
// s_ready is high only while idle; a result waits in the output register while the next item runs
`timescale 1ns / 1ps

module bitmap_page_frame_allocator_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [bpfa_pkg::OP_W-1:0]         s_opcode,
    input  logic [bpfa_pkg::ADDR_W-1:0]       s_address,
    input  logic [bpfa_pkg::ADDR_W-1:0]       s_region_length,
    input  logic [bpfa_pkg::TYPE_W-1:0]       s_region_type,
    input  logic [bpfa_pkg::RUN_W-1:0]        s_run_count,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_ok,
    output logic [bpfa_pkg::IDX_W-1:0]        m_frame_idx,
    output logic [bpfa_pkg::STATUS_W-1:0]     m_status
);

    typedef enum logic [6:0] {
        FSM_IDLE      = 7'b0000001,
        FSM_SETUP     = 7'b0000010,
        FSM_FIND_BASE = 7'b0000100,
        FSM_FIND_USED = 7'b0001000,
        FSM_FIND_FREE = 7'b0010000,
        FSM_RANGE     = 7'b0100000,
        FSM_DONE      = 7'b1000000
    } fsm_t;

    function automatic logic [bpfa_pkg::PCNT_W-1:0] clip_page(
        input logic [bpfa_pkg::ADDR_W:0] v
    );
        clip_page = (v >= (bpfa_pkg::ADDR_W + 1)'(bpfa_pkg::MAX_PAGE_COUNT)) ?
                    bpfa_pkg::PCNT_W'(bpfa_pkg::MAX_PAGE_COUNT) :
                    v[bpfa_pkg::PCNT_W-1:0];
    endfunction

    function automatic logic [bpfa_pkg::WIDX_W-1:0] word_of(
        input logic [bpfa_pkg::PCNT_W-1:0] p
    );
        word_of = p[bpfa_pkg::PCNT_W-1:bpfa_pkg::BIT_W];
    endfunction

    fsm_t                               state_reg, state_next;
    bpfa_pkg::op_t                      op_reg;
    logic [bpfa_pkg::ADDR_W-1:0]        addr_reg;
    logic [bpfa_pkg::ADDR_W-1:0]        len_reg;
    logic [bpfa_pkg::TYPE_W-1:0]        type_reg;
    logic [bpfa_pkg::RUN_W-1:0]         count_reg;

    logic [bpfa_pkg::PCNT_W-1:0]        lo_reg, lo_next;
    logic [bpfa_pkg::PCNT_W-1:0]        hi_reg, hi_next;
    logic                               find_used_reg, find_used_next;
    logic                               set_reg, set_next;
    logic [bpfa_pkg::PAGE_W-1:0]        base_reg, base_next;
    logic [bpfa_pkg::WIDX_W-1:0]        issue_reg, issue_next;
    logic                               stage_vld_reg, stage_vld_next;
    logic [bpfa_pkg::WADDR_W-1:0]       stage_idx_reg, stage_idx_next;

    logic [bpfa_pkg::WORD_BITS-1:0]     mem [bpfa_pkg::WORD_COUNT];
    logic [bpfa_pkg::WORD_BITS-1:0]     rd_data_reg;
    logic                               rd_rowv_reg;
    logic [bpfa_pkg::WORD_COUNT-1:0]    row_valid_reg, row_valid_next;

    logic                               res_ok_reg, res_ok_next;
    logic [bpfa_pkg::IDX_W-1:0]         res_page_reg, res_page_next;
    bpfa_pkg::status_t                  res_status_reg, res_status_next;

    logic                               m_valid_reg, m_valid_next;
    logic                               m_ok_reg;
    logic [bpfa_pkg::IDX_W-1:0]         m_page_reg;
    logic [bpfa_pkg::STATUS_W-1:0]      m_status_reg;
    logic                               out_load;

    bpfa_pkg::unit_ctl_t                unit_ctl;
    bpfa_pkg::unit_res_t                unit_res;
    logic [bpfa_pkg::WORD_BITS-1:0]     eff_word;

    logic                               accept;
    logic                               issue_go;
    logic                               scan_hit;
    logic                               scan_miss;
    logic                               mem_we;
    logic [bpfa_pkg::PAGE_W-1:0]        hit_page;
    logic [bpfa_pkg::PCNT_W-1:0]        hit_page_ext;
    logic [bpfa_pkg::PCNT_W-1:0]        fail_page;
    logic [bpfa_pkg::RUN_END_W-1:0]     run_end;

    logic [bpfa_pkg::ADDR_W:0]          addr_ext;
    logic [bpfa_pkg::ADDR_W:0]          ceil_pg;
    logic [bpfa_pkg::ADDR_W:0]          end_sum;
    logic [bpfa_pkg::ADDR_W-1:0]        end_sat;
    logic [bpfa_pkg::ADDR_W:0]          floor_pg;
    logic [bpfa_pkg::ADDR_W:0]          free_pg;
    logic [bpfa_pkg::PCNT_W-1:0]        ceil_clip;
    logic [bpfa_pkg::PCNT_W-1:0]        floor_clip;
    logic                               free_ok;

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == FSM_IDLE);

    // command address math
    assign addr_ext   = {1'b0, addr_reg};
    assign ceil_pg    = (addr_ext + (bpfa_pkg::ADDR_W + 1)'(bpfa_pkg::PAGE_BYTES - 1))
                        >> bpfa_pkg::PAGE_SHIFT;
    assign end_sum    = addr_ext + {1'b0, len_reg};
    assign end_sat    = end_sum[bpfa_pkg::ADDR_W] ? '1 : end_sum[bpfa_pkg::ADDR_W-1:0];
    assign floor_pg   = {1'b0, end_sat} >> bpfa_pkg::PAGE_SHIFT;
    assign free_pg    = addr_ext >> bpfa_pkg::PAGE_SHIFT;
    assign ceil_clip  = clip_page(ceil_pg);
    assign floor_clip = clip_page(floor_pg);
    assign free_ok    = (addr_reg[bpfa_pkg::PAGE_SHIFT-1:0] == '0) &&
                        (free_pg < (bpfa_pkg::ADDR_W + 1)'(bpfa_pkg::MAX_PAGE_COUNT));

    // shared word unit on the data stage
    assign eff_word = rd_rowv_reg ? rd_data_reg : '1;

    assign unit_ctl.lo        = lo_reg;
    assign unit_ctl.hi        = hi_reg;
    assign unit_ctl.find_used = find_used_reg;
    assign unit_ctl.set_bits  = set_reg;

    bpfa_word_unit u_word_unit (
        .ctl  (unit_ctl),
        .widx (stage_idx_reg),
        .word (eff_word),
        .res  (unit_res)
    );

    always_comb begin
        issue_go = 1'b0;
        if (state_reg inside {FSM_FIND_BASE, FSM_FIND_USED, FSM_FIND_FREE}) begin
            issue_go = (issue_reg < bpfa_pkg::WIDX_W'(bpfa_pkg::WORD_COUNT));
        end else if (state_reg == FSM_RANGE) begin
            issue_go = ((bpfa_pkg::PCNT_W + 1)'({issue_reg, {bpfa_pkg::BIT_W{1'b0}}}) <
                        (bpfa_pkg::PCNT_W + 1)'(hi_reg));
        end
    end

    assign scan_hit     = stage_vld_reg && unit_res.hit;
    assign scan_miss    = !stage_vld_reg && !issue_go;
    assign hit_page     = {stage_idx_reg, unit_res.bit_sel};
    assign hit_page_ext = bpfa_pkg::PCNT_W'(hit_page);
    assign fail_page    = scan_hit ? hit_page_ext : bpfa_pkg::PCNT_W'(bpfa_pkg::MAX_PAGE_COUNT);
    assign run_end      = bpfa_pkg::RUN_END_W'(base_reg) + bpfa_pkg::RUN_END_W'(count_reg);
    assign mem_we       = (state_reg == FSM_RANGE) && stage_vld_reg;
    assign out_load     = (state_reg == FSM_DONE) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next      = state_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        find_used_next  = find_used_reg;
        set_next        = set_reg;
        base_next       = base_reg;
        issue_next      = issue_reg;
        stage_vld_next  = 1'b0;
        stage_idx_next  = issue_reg[bpfa_pkg::WADDR_W-1:0];
        row_valid_next  = row_valid_reg;
        res_ok_next     = res_ok_reg;
        res_page_next   = res_page_reg;
        res_status_next = res_status_reg;

        if (issue_go) begin
            stage_vld_next = 1'b1;
            issue_next     = issue_reg + bpfa_pkg::WIDX_W'(1);
        end
        if (mem_we) begin
            row_valid_next[stage_idx_reg] = 1'b1;
        end

        case (state_reg)
            FSM_IDLE: begin
                if (accept) begin
                    state_next = FSM_SETUP;
                end
            end
            FSM_SETUP: begin
                res_ok_next     = 1'b1;
                res_page_next   = '0;
                res_status_next = bpfa_pkg::STATUS_DONE;
                stage_vld_next  = 1'b0;
                state_next      = FSM_DONE;
                case (op_reg)
                    bpfa_pkg::OP_FILL_USED: begin
                        row_valid_next = '0;
                    end
                    bpfa_pkg::OP_ADD_REGION: begin
                        lo_next  = ceil_clip;
                        hi_next  = floor_clip;
                        set_next = 1'b0;
                        issue_next = word_of(ceil_clip);
                        if (type_reg == bpfa_pkg::REGION_USABLE && ceil_clip < floor_clip) begin
                            state_next = FSM_RANGE;
                        end
                    end
                    bpfa_pkg::OP_RESERVE_BELOW: begin
                        lo_next    = '0;
                        hi_next    = ceil_clip;
                        set_next   = 1'b1;
                        issue_next = '0;
                        if (ceil_clip != '0) begin
                            state_next = FSM_RANGE;
                        end
                    end
                    bpfa_pkg::OP_ALLOC_ONE: begin
                        lo_next        = '0;
                        hi_next        = bpfa_pkg::PCNT_W'(bpfa_pkg::MAX_PAGE_COUNT);
                        find_used_next = 1'b0;
                        issue_next     = '0;
                        state_next     = FSM_FIND_BASE;
                    end
                    bpfa_pkg::OP_FREE_ONE: begin
                        lo_next    = bpfa_pkg::PCNT_W'(free_pg);
                        hi_next    = bpfa_pkg::PCNT_W'(free_pg) + bpfa_pkg::PCNT_W'(1);
                        set_next   = 1'b0;
                        issue_next = word_of(bpfa_pkg::PCNT_W'(free_pg));
                        if (free_ok) begin
                            state_next = FSM_RANGE;
                        end else begin
                            res_ok_next     = 1'b0;
                            res_status_next = bpfa_pkg::STATUS_REJECTED;
                        end
                    end
                    bpfa_pkg::OP_ALLOC_RUN: begin
                        lo_next        = '0;
                        hi_next        = bpfa_pkg::PCNT_W'(bpfa_pkg::MAX_PAGE_COUNT);
                        find_used_next = 1'b0;
                        issue_next     = '0;
                        if (count_reg == '0) begin
                            res_ok_next     = 1'b0;
                            res_status_next = bpfa_pkg::STATUS_NOT_CONTIG;
                        end else begin
                            state_next = FSM_FIND_BASE;
                        end
                    end
                    default: begin
                        res_ok_next     = 1'b0;
                        res_status_next = bpfa_pkg::STATUS_REJECTED;
                    end
                endcase
            end
            FSM_FIND_BASE: begin
                if (scan_hit) begin
                    stage_vld_next = 1'b0;
                    if (op_reg == bpfa_pkg::OP_ALLOC_ONE || hit_page == '0) begin
                        // mark the one page used
                        lo_next    = hit_page_ext;
                        hi_next    = hit_page_ext + bpfa_pkg::PCNT_W'(1);
                        set_next   = 1'b1;
                        issue_next = word_of(hit_page_ext);
                        state_next = FSM_RANGE;
                        if (op_reg == bpfa_pkg::OP_ALLOC_ONE) begin
                            res_ok_next     = 1'b1;
                            res_page_next   = bpfa_pkg::IDX_W'(hit_page);
                            res_status_next = bpfa_pkg::STATUS_DONE;
                        end else begin
                            res_ok_next     = 1'b0;
                            res_page_next   = '0;
                            res_status_next = bpfa_pkg::STATUS_NOT_CONTIG;
                        end
                    end else begin
                        base_next      = hit_page;
                        lo_next        = hit_page_ext + bpfa_pkg::PCNT_W'(1);
                        find_used_next = 1'b1;
                        issue_next     = word_of(hit_page_ext + bpfa_pkg::PCNT_W'(1));
                        state_next     = FSM_FIND_USED;
                    end
                end else if (scan_miss) begin
                    res_ok_next     = 1'b0;
                    res_page_next   = '0;
                    res_status_next = bpfa_pkg::STATUS_NO_FREE;
                    state_next      = FSM_DONE;
                end
            end
            FSM_FIND_USED: begin
                if (scan_hit || scan_miss) begin
                    stage_vld_next = 1'b0;
                    if (bpfa_pkg::RUN_END_W'(fail_page) < run_end) begin
                        res_ok_next   = 1'b0;
                        res_page_next = '0;
                        if (scan_miss) begin
                            res_status_next = bpfa_pkg::STATUS_NO_FREE;
                            state_next      = FSM_DONE;
                        end else begin
                            lo_next        = hit_page_ext;
                            find_used_next = 1'b0;
                            issue_next     = word_of(hit_page_ext);
                            state_next     = FSM_FIND_FREE;
                        end
                    end else begin
                        lo_next         = bpfa_pkg::PCNT_W'(base_reg);
                        hi_next         = run_end[bpfa_pkg::PCNT_W-1:0];
                        set_next        = 1'b1;
                        issue_next      = word_of(bpfa_pkg::PCNT_W'(base_reg));
                        res_ok_next     = 1'b1;
                        res_page_next   = bpfa_pkg::IDX_W'(base_reg);
                        res_status_next = bpfa_pkg::STATUS_DONE;
                        state_next      = FSM_RANGE;
                    end
                end
            end
            FSM_FIND_FREE: begin
                if (scan_hit) begin
                    res_status_next = bpfa_pkg::STATUS_NOT_CONTIG;
                    state_next      = FSM_DONE;
                end else if (scan_miss) begin
                    res_status_next = bpfa_pkg::STATUS_NO_FREE;
                    state_next      = FSM_DONE;
                end
            end
            FSM_RANGE: begin
                if (!issue_go && !stage_vld_reg) begin
                    state_next = FSM_DONE;
                end
            end
            FSM_DONE: begin
                if (out_load) begin
                    state_next = FSM_IDLE;
                end
            end
            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= FSM_IDLE;
            stage_vld_reg <= 1'b0;
            row_valid_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            stage_vld_reg <= stage_vld_next;
            row_valid_reg <= row_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg    <= bpfa_pkg::op_t'(s_opcode);
            addr_reg  <= s_address;
            len_reg   <= s_region_length;
            type_reg  <= s_region_type;
            count_reg <= s_run_count;
        end
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        find_used_reg  <= find_used_next;
        set_reg        <= set_next;
        base_reg       <= base_next;
        issue_reg      <= issue_next;
        stage_idx_reg  <= stage_idx_next;
        rd_rowv_reg    <= row_valid_reg[issue_reg[bpfa_pkg::WADDR_W-1:0]];
        res_ok_reg     <= res_ok_next;
        res_page_reg   <= res_page_next;
        res_status_reg <= res_status_next;
        if (out_load) begin
            m_ok_reg     <= res_ok_reg;
            m_page_reg   <= res_page_reg;
            m_status_reg <= res_status_reg;
        end
    end

    // bitmap memory
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[stage_idx_reg] <= unit_res.new_word;
        end
        rd_data_reg <= mem[issue_reg[bpfa_pkg::WADDR_W-1:0]];
    end

    assign m_valid     = m_valid_reg;
    assign m_ok        = m_ok_reg;
    assign m_frame_idx = m_page_reg;
    assign m_status    = m_status_reg;

endmodule

/* hdl/bpfa_checker.sv */
// port checker for the bitmap page frame allocator and its bind
`timescale 1ns / 1ps

module bpfa_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic [bpfa_pkg::OP_W-1:0]         s_opcode,
    input logic [bpfa_pkg::ADDR_W-1:0]       s_address,
    input logic [bpfa_pkg::ADDR_W-1:0]       s_region_length,
    input logic [bpfa_pkg::TYPE_W-1:0]       s_region_type,
    input logic [bpfa_pkg::RUN_W-1:0]        s_run_count,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic                              m_ok,
    input logic [bpfa_pkg::IDX_W-1:0]        m_frame_idx,
    input logic [bpfa_pkg::STATUS_W-1:0]     m_status
);

    // one item at a time
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("s_ready high right after an item was taken");

    a_ok_matches_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_ok == (m_status == bpfa_pkg::STATUS_DONE)))
        else $error("m_ok disagrees with m_status");

    a_fail_no_page: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ok) |-> (m_frame_idx == '0))
        else $error("failed item carries a page index");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_ok) && $stable(m_frame_idx) &&
                                   $stable(m_status)))
        else $error("stalled result dropped or changed");

endmodule

bind bitmap_page_frame_allocator_core bpfa_checker u_bpfa_checker (.*);

/* verif/tb_bitmap_page_frame_allocator_core.sv */
// self-checking testbench for the bitmap page frame allocator core
`timescale 1ns / 1ps

module tb_bitmap_page_frame_allocator_core;
    import bpfa_pkg::*;

    localparam int          RANDOM_ITEMS = 1500;
    localparam int          LIMIT_CYCLES = 2000000;
    localparam int          DRAIN_CYCLES = 300;
    localparam int          HOLD_CYCLES  = 2000;
    localparam int          REPORT_MAX   = 10;
    localparam longint      ADDR_TOP     = 64'hFFFF_FFFF;
    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    typedef struct {
        logic [OP_W-1:0]   opcode;
        logic [ADDR_W-1:0] address;
        logic [ADDR_W-1:0] region_length;
        logic [TYPE_W-1:0] region_type;
        logic [RUN_W-1:0]  run_count;
    } alloc_cmd_t;

    typedef struct {
        logic                ok;
        logic [IDX_W-1:0]    frame_idx;
        logic [STATUS_W-1:0] status;
    } alloc_resp_t;

    logic                aclk;
    logic                aresetn         = 1'b0;
    logic                s_valid         = 1'b0;
    logic                s_ready;
    logic [OP_W-1:0]     s_opcode        = '0;
    logic [ADDR_W-1:0]   s_address       = '0;
    logic [ADDR_W-1:0]   s_region_length = '0;
    logic [TYPE_W-1:0]   s_region_type   = '0;
    logic [RUN_W-1:0]    s_run_count     = '0;
    logic                m_valid;
    logic                m_ready         = 1'b0;
    logic                m_ok;
    logic [IDX_W-1:0]    m_frame_idx;
    logic [STATUS_W-1:0] m_status;

    alloc_cmd_t  pending_cmds[$];
    alloc_resp_t expected_resps[$];
    alloc_cmd_t  offered_cmd;
    bit          frame_used[MAX_PAGE_COUNT];
    int          total_items    = 0;
    int          n_accepted     = 0;
    int          n_results      = 0;
    int          mismatch_count = 0;
    int          cycle_count    = 0;
    int          hold_left      = 0;
    bit          hold_done      = 1'b0;

    bitmap_page_frame_allocator_core DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_address       (s_address),
        .s_region_length (s_region_length),
        .s_region_type   (s_region_type),
        .s_run_count     (s_run_count),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_ok            (m_ok),
        .m_frame_idx     (m_frame_idx),
        .m_status        (m_status)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // set or clear frames lo up to hi, clipped to the table
    function automatic void mark_frames(longint unsigned lo, longint unsigned hi, bit v);
        longint unsigned p;
        if (hi > MAX_PAGE_COUNT) hi = MAX_PAGE_COUNT;
        for (p = lo; p < hi; p++) frame_used[p] = v;
    endfunction

    // lowest free frame at or above from, -1 if none
    function automatic int lowest_free(longint unsigned from);
        longint unsigned p;
        for (p = from; p < MAX_PAGE_COUNT; p++) begin
            if (!frame_used[p]) return int'(p);
        end
        return -1;
    endfunction

    function automatic alloc_resp_t compute_response(alloc_cmd_t c);
        alloc_resp_t     r;
        longint unsigned addr;
        longint unsigned len;
        longint unsigned region_end;
        longint unsigned pb;
        longint unsigned count;
        longint unsigned k;
        longint unsigned p;
        int              base;
        bit              broken;
        addr   = c.address;
        len    = c.region_length;
        count  = c.run_count;
        pb     = PAGE_BYTES;
        broken = 1'b0;
        r.ok        = 1'b0;
        r.frame_idx = '0;
        r.status    = STATUS_DONE;
        case (c.opcode)
            OP_FILL_USED: begin
                mark_frames(0, MAX_PAGE_COUNT, 1'b1);
                r.ok = 1'b1;
            end
            OP_ADD_REGION: begin
                if (c.region_type == REGION_USABLE) begin
                    region_end = addr + len;
                    if (region_end > ADDR_TOP) region_end = ADDR_TOP;
                    mark_frames((addr + pb - 1) / pb, region_end / pb, 1'b0);
                end
                r.ok = 1'b1;
            end
            OP_RESERVE_BELOW: begin
                mark_frames(0, (addr + pb - 1) / pb, 1'b1);
                r.ok = 1'b1;
            end
            OP_ALLOC_ONE: begin
                base = lowest_free(0);
                if (base < 0) begin
                    r.status = STATUS_NO_FREE;
                end else begin
                    frame_used[base] = 1'b1;
                    r.ok        = 1'b1;
                    r.frame_idx = IDX_W'(base);
                end
            end
            OP_FREE_ONE: begin
                if ((addr % pb) != 0 || (addr / pb) >= MAX_PAGE_COUNT) begin
                    r.status = STATUS_REJECTED;
                end else begin
                    frame_used[addr / pb] = 1'b0;
                    r.ok = 1'b1;
                end
            end
            OP_ALLOC_RUN: begin
                base = (count == 0) ? -1 : lowest_free(0);
                if (count == 0) begin
                    r.status = STATUS_NOT_CONTIG;
                end else if (base < 0) begin
                    r.status = STATUS_NO_FREE;
                end else if (base == 0) begin
                    // a run found at frame zero fails but keeps frame zero taken
                    frame_used[0] = 1'b1;
                    r.status = STATUS_NOT_CONTIG;
                end else begin
                    k = 1;
                    while (!broken && k < count) begin
                        p = longint'(base) + k;
                        if (p >= MAX_PAGE_COUNT || frame_used[p]) begin
                            broken   = 1'b1;
                            r.status = (lowest_free(p) < 0) ? STATUS_NO_FREE
                                                            : STATUS_NOT_CONTIG;
                        end
                        k++;
                    end
                    if (!broken) begin
                        mark_frames(base, longint'(base) + count, 1'b1);
                        r.ok        = 1'b1;
                        r.frame_idx = IDX_W'(base);
                    end
                end
            end
            default: begin
                r.status = STATUS_REJECTED;
            end
        endcase
        return r;
    endfunction

    function automatic alloc_cmd_t make_cmd(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr,
                                            logic [ADDR_W-1:0] len, logic [TYPE_W-1:0] rtype,
                                            logic [RUN_W-1:0] count);
        alloc_cmd_t c;
        c.opcode        = op;
        c.address       = addr;
        c.region_length = len;
        c.region_type   = rtype;
        c.run_count     = count;
        return c;
    endfunction

    function automatic alloc_cmd_t random_cmd();
        alloc_cmd_t c;
        int         sel;
        c   = make_cmd(OP_ALLOC_ONE, $urandom, $urandom, TYPE_W'($urandom), RUN_W'($urandom));
        sel = $urandom_range(0, 99);
        if (sel < 3) begin
            c.opcode = OP_FILL_USED;
        end else if (sel < 20) begin
            c.opcode        = OP_ADD_REGION;
            c.region_type   = REGION_USABLE;
            c.address       = ADDR_W'($urandom_range(0, MAX_PAGE_COUNT - 1)) * PAGE_BYTES;
            c.region_length = ADDR_W'($urandom_range(1, 64)) * PAGE_BYTES;
            if ($urandom_range(0, 3) == 0) c.address += $urandom_range(0, PAGE_BYTES - 1);
            if ($urandom_range(0, 3) == 0) c.region_length += $urandom_range(0, PAGE_BYTES - 1);
        end else if (sel < 24) begin
            c.opcode = OP_ADD_REGION;
            if ($urandom_range(0, 1) == 0) c.region_type = REGION_USABLE;
        end else if (sel < 28) begin
            c.opcode = OP_RESERVE_BELOW;
            if ($urandom_range(0, 7) != 0) c.address = $urandom_range(0, 64 * PAGE_BYTES);
        end else if (sel < 48) begin
            c.opcode = OP_ALLOC_ONE;
        end else if (sel < 66) begin
            c.opcode  = OP_FREE_ONE;
            c.address = ADDR_W'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 127)
                                : $urandom_range(0, MAX_PAGE_COUNT - 1)) * PAGE_BYTES;
        end else if (sel < 70) begin
            c.opcode = OP_FREE_ONE;
        end else if (sel < 95) begin
            c.opcode = OP_ALLOC_RUN;
            if ($urandom_range(0, 19) == 0) c.run_count = '0;
            else if ($urandom_range(0, 9) != 0) c.run_count = RUN_W'($urandom_range(1, 12));
        end else begin
            c.opcode = OP_W'($urandom_range(0, 7));
        end
        return c;
    endfunction

    function automatic int sender_idle_pct();
        if (n_accepted < total_items / 3) return 10;
        if (n_accepted < 2 * total_items / 3) return 78;
        return 0;
    endfunction

    function automatic int receiver_idle_pct();
        if (n_accepted < total_items / 3) return 78;
        if (n_accepted < 2 * total_items / 3) return 10;
        return 0;
    endfunction

    // driver
    always @(posedge aclk) begin
        alloc_cmd_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_resps.push_back(compute_response(offered_cmd));
                n_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
                    nxt             = pending_cmds.pop_front();
                    offered_cmd     = nxt;
                    s_opcode        <= nxt.opcode;
                    s_address       <= nxt.address;
                    s_region_length <= nxt.region_length;
                    s_region_type   <= nxt.region_type;
                    s_run_count     <= nxt.run_count;
                    s_valid         <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and checker
    always @(posedge aclk) begin
        alloc_resp_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                n_results++;
                if (expected_resps.size() == 0) begin
                    if (mismatch_count < REPORT_MAX)
                        $display("result %0d with no item outstanding: ok=%0d idx=%0d st=%0d",
                                 n_results, m_ok, m_frame_idx, m_status);
                    mismatch_count++;
                end else begin
                    want = expected_resps.pop_front();
                    if (m_ok !== want.ok || m_frame_idx !== want.frame_idx
                        || m_status !== want.status) begin
                        if (mismatch_count < REPORT_MAX)
                            $display(
                                "result %0d: exp ok %0d idx %0d st %0d, got ok %0d idx %0d st %0d",
                                n_results, want.ok, want.frame_idx, want.status,
                                m_ok, m_frame_idx, m_status);
                        mismatch_count++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!hold_done && n_accepted >= 2 * total_items / 3 + 100) begin
                // long back-pressure so the block fills and stalls its input
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                m_ready  <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= receiver_idle_pct());
            end
        end
    end

    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        // table starts all used
        pending_cmds.push_back(make_cmd(OP_ALLOC_ONE, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(OP_ALLOC_RUN, 0, 0, 0, 4));
        pending_cmds.push_back(make_cmd(OP_ALLOC_RUN, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(OP_ADD_REGION, 32'h0000_0000, 32'h0001_0000, 8'h00, 0));
        // unaligned region frees frames 11 and 12, then 14 to 16
        pending_cmds.push_back(make_cmd(OP_ADD_REGION, 32'h0000_A001, 32'h0000_2FFF,
                                        REGION_USABLE, 0));
        pending_cmds.push_back(make_cmd(OP_ADD_REGION, 32'h0000_E000, 32'h0000_3000,
                                        REGION_USABLE, 0));
        pending_cmds.push_back(make_cmd(OP_ALLOC_RUN, 0, 0, 0, 5));
        pending_cmds.push_back(make_cmd(OP_ALLOC_RUN, 0, 0, 0, 2));
        pending_cmds.push_back(make_cmd(OP_ALLOC_RUN, 0, 0, 0, 4));
        // run starting at frame zero
        pending_cmds.push_back(make_cmd(OP_FREE_ONE, 32'h0000_0000, 0, 0, 0));
        pending_cmds.push_back(make_cmd(OP_ALLOC_RUN, 0, 0, 0, 3));
        pending_cmds.push_back(make_cmd(OP_FREE_ONE, 32'h0000_0000, 0, 0, 0));
        pending_cmds.push_back(make_cmd(OP_ALLOC_ONE, 0, 0, 0, 0));
        // run that leaves the table at the last frame
        pending_cmds.push_back(make_cmd(OP_RESERVE_BELOW, 32'h0001_1001, 0, 0, 0));
        pending_cmds.push_back(make_cmd(OP_FREE_ONE, 32'h00FF_F000, 0, 0, 0));
        pending_cmds.push_back(make_cmd(OP_ALLOC_RUN, 0, 0, 0, 13'h1FFF));
        pending_cmds.push_back(make_cmd(OP_ALLOC_RUN, 0, 0, 0, 1));
        pending_cmds.push_back(make_cmd(OP_FREE_ONE, 32'h0000_1234, 0, 0, 0));
        pending_cmds.push_back(make_cmd(OP_FREE_ONE, 32'h0100_0000, 0, 0, 0));
        pending_cmds.push_back(make_cmd(OP_ADD_REGION, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                        REGION_USABLE, 0));
        pending_cmds.push_back(make_cmd(OP_ADD_REGION, 32'h0000_0000, 32'hFFFF_FFFF,
                                        REGION_USABLE, 0));
        pending_cmds.push_back(make_cmd(OP_ALLOC_RUN, 0, 0, 0, 13'h1000));
        pending_cmds.push_back(make_cmd(OP_RESERVE_BELOW, 32'hFFFF_FFFF, 0, 0, 0));
        pending_cmds.push_back(make_cmd(OP_SPARE_LO, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF,
                                        13'h1FFF));
        pending_cmds.push_back(make_cmd(OP_SPARE_HI, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(OP_FILL_USED, 0, 0, 0, 0));
        repeat (RANDOM_ITEMS) pending_cmds.push_back(random_cmd());
        total_items = pending_cmds.size();
        mark_frames(0, MAX_PAGE_COUNT, 1'b1);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (n_accepted < total_items) @(posedge aclk);
        while (expected_resps.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && expected_resps.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* files.f */
hdl/bpfa_pkg.sv
hdl/bpfa_word_unit.sv
hdl/bitmap_page_frame_allocator_core.sv
hdl/bpfa_checker.sv
verif/tb_bitmap_page_frame_allocator_core.sv
